[design/text_console_framebuffer_defines.svh]
// ----------------------------------------------------------------------------
// Text console framebuffer assertion macros
// Shared concurrent assertion helpers. They are empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_FRAMEBUFFER_DEFINES_SVH
`define TEXT_CONSOLE_FRAMEBUFFER_DEFINES_SVH

`ifndef SYNTHESIS
`define TCF_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define TCF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TCF_ASSERT(label, expr, msg)
`define TCF_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

[design/tcf_pkg.sv]
// ----------------------------------------------------------------------------
// Text console framebuffer package
// Beat types, sequencer states, size defaults and the 5x8 font table.
// ----------------------------------------------------------------------------
package tcf_pkg;

  localparam int SCREEN_W_DEF = 128;
  localparam int SCREEN_H_DEF = 64;
  localparam int GLYPH_W_DEF  = 5;
  localparam int GLYPH_H      = 8;
  localparam int FONT_FIRST   = 32;
  localparam int FONT_LAST    = 126;
  localparam int FONT_COLS    = 5;
  localparam int FONT_CHARS   = FONT_LAST - FONT_FIRST + 1;

  localparam logic [1:0] REQ_DRAW   = 2'd0;
  localparam logic [1:0] REQ_SCROLL = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;

  typedef struct packed {
    logic [1:0] req_type;
    logic [6:0] pos_x;
    logic [5:0] pos_y;
    logic [7:0] char_code;
    logic [6:0] scroll_rows;
    logic [9:0] byte_addr;
  } tcf_in_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic [1:0] done_kind;
  } tcf_out_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DRAW_RD,
    ST_DRAW_WR,
    ST_SCROLL,
    ST_READ,
    ST_DONE
  } tcf_state_t;

  // Column 0 of each glyph sits in the top byte; bit r of a column is cell row r.
  localparam logic [39:0] FONT_ROM [FONT_CHARS] = '{
    40'h0000000000, 40'h00002E0000, 40'h0600060000,
    40'h147F147F14, 40'h06497F4930, 40'h2410082400,
    40'h3649365000, 40'h0000000600, 40'h0036410000,
    40'h0041360000, 40'h0008000000, 40'h00081C0800,
    40'h4020000000, 40'h0008080000, 40'h2000000000,
    40'h0030060000, 40'h3641413600, 40'h0000003600,
    40'h3049490600, 40'h0049493600, 40'h0608083600,
    40'h0649493000, 40'h3649493000, 40'h0001013600,
    40'h3649493600, 40'h0649493600, 40'h0014000000,
    40'h2014000000, 40'h0008142200, 40'h0014141400,
    40'h0022140800, 40'h0001310600, 40'h364955592E,
    40'h3609093600, 40'h7749493600, 40'h3641410000,
    40'h7741413600, 40'h3649490000, 40'h3609090000,
    40'h3641513000, 40'h3608083600, 40'h0000360000,
    40'h0040403600, 40'h3608142200, 40'h3640400000,
    40'h3601060136, 40'h3604103600, 40'h3641413600,
    40'h3609090600, 40'h3641215600, 40'h3609192600,
    40'h0649493000, 40'h0001370100, 40'h3640403600,
    40'h3640360000, 40'h3640304036, 40'h3608083600,
    40'h0648483600, 40'h2051494502, 40'h7741410000,
    40'h0006300000, 40'h0041417700, 40'h0002010200,
    40'h0040400000, 40'h0001020000, 40'h2054543840,
    40'h0036483000, 40'h3048480000, 40'h3048487600,
    40'h3854540800, 40'h086C0A0000, 40'h0854543800,
    40'h3608083000, 40'h0034000000, 40'h0040340000,
    40'h3610280000, 40'h3600000000, 40'h3008100830,
    40'h3008083000, 40'h3048483000, 40'h7814140800,
    40'h0814146800, 40'h3008080000, 40'h0854542000,
    40'h082C480000, 40'h3040403000, 40'h3040300000,
    40'h3040204030, 40'h2810102800, 40'h0850503800,
    40'h24342C2400, 40'h0836410000, 40'h0036000000,
    40'h0041360800, 40'h0808101000
  };

  // All five columns of a character; codes outside the font are blank.
  function automatic logic [39:0] glyph_bits(input logic [7:0] code);
    logic [39:0] bits;
    logic [7:0]  idx;
    bits = '0;
    idx  = code - 8'(FONT_FIRST);
    if (code >= 8'(FONT_FIRST) && code <= 8'(FONT_LAST)) begin
      bits = FONT_ROM[idx[6:0]];
    end
    return bits;
  endfunction

endpackage

[design/tcf_ram.sv]
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tcf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/tcf_ctrl.sv]
// ----------------------------------------------------------------------------
// Text console framebuffer sequencer
// Clearing pass, glyph read-modify-write, scroll sweep and byte reads.
// ----------------------------------------------------------------------------
`include "text_console_framebuffer_defines.svh"

module tcf_ctrl #(
  parameter int SCREEN_W = tcf_pkg::SCREEN_W_DEF,
  parameter int SCREEN_H = tcf_pkg::SCREEN_H_DEF,
  parameter int GLYPH_W  = tcf_pkg::GLYPH_W_DEF,
  parameter int AW       = $clog2(SCREEN_W * SCREEN_H / 8)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  tcf_pkg::tcf_in_t in_data,
  output logic             mem_we,
  output logic [AW-1:0]    mem_waddr,
  output logic [7:0]       mem_wdata,
  output logic [AW-1:0]    mem_raddr,
  input  logic [7:0]       mem_rdata,
  output logic             fin_valid,
  input  logic             fin_ready,
  output tcf_pkg::tcf_out_t fin_data
);

  import tcf_pkg::*;

  localparam int FB_PIXELS = SCREEN_W * SCREEN_H;
  localparam int FB_BYTES  = FB_PIXELS / 8;
  localparam int CNT_W     = $clog2(FB_BYTES + 1);
  localparam int COL_W     = (GLYPH_W > 1) ? $clog2(GLYPH_W) : 1;
  localparam int LIN_MAX   = (64 + GLYPH_H) * SCREEN_W + 128 + GLYPH_W;
  localparam int LIN_W     = $clog2(LIN_MAX + FB_PIXELS);
  localparam int SHW       = $clog2(FB_PIXELS + 1);

  tcf_state_t        state_r, state_nxt;
  logic [39:0]       glyph_r, glyph_nxt;
  logic [6:0]        x_r, x_nxt;
  logic [5:0]        y_r, y_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [2:0]        row_r, row_nxt;
  logic [CNT_W-1:0]  sweep_r, sweep_nxt;
  logic [CNT_W-1:0]  shift_r, shift_nxt;
  logic              pend_r, pend_nxt;
  logic [AW-1:0]     pdst_r, pdst_nxt;
  logic              pzero_r, pzero_nxt;
  logic [1:0]        kind_r, kind_nxt;
  logic [7:0]        res_r, res_nxt;
  logic              rd_ok_r, rd_ok_nxt;

  logic [LIN_W-1:0]  pix_lin;
  logic              pix_ok;
  logic [7:0]        colbits;
  logic [7:0]        pix_mask;
  logic [CNT_W:0]    src;
  logic [6:0]        rows_sat;
  logic [SHW-1:0]    shift_full;

  always_comb begin
    pix_lin = LIN_W'((LIN_W'(y_r) + LIN_W'(row_r)) * LIN_W'(SCREEN_W))
            + LIN_W'(x_r) + LIN_W'(col_r);
    pix_ok  = (pix_lin < LIN_W'(FB_PIXELS));
    colbits = '0;
    for (int c = 0; c < FONT_COLS; c++) begin
      if (c < GLYPH_W && int'(col_r) == c) begin
        colbits = glyph_r[(FONT_COLS - 1 - c) * 8 +: 8];
      end
    end
    pix_mask = 8'h80 >> pix_lin[2:0];
    src      = (CNT_W + 1)'(sweep_r) + (CNT_W + 1)'(shift_r);
    rows_sat = (int'(in_data.scroll_rows) > SCREEN_H) ? 7'(SCREEN_H) : in_data.scroll_rows;
    shift_full = SHW'(SHW'(rows_sat) * SHW'(SCREEN_W)) >> 3;
  end

  always_comb begin
    state_nxt = state_r;
    glyph_nxt = glyph_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    sweep_nxt = sweep_r;
    shift_nxt = shift_r;
    pend_nxt  = 1'b0;
    pdst_nxt  = pdst_r;
    pzero_nxt = pzero_r;
    kind_nxt  = kind_r;
    res_nxt   = res_r;
    rd_ok_nxt = rd_ok_r;
    mem_we    = pend_r;
    mem_waddr = pdst_r;
    mem_wdata = pzero_r ? 8'h00 : mem_rdata;
    mem_raddr = AW'(in_data.byte_addr);
    in_stall  = (state_r != ST_IDLE);
    fin_valid = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_r[AW-1:0];
        mem_wdata = 8'h00;
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == CNT_W'(FB_BYTES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          kind_nxt  = in_data.req_type;
          res_nxt   = 8'h00;
          x_nxt     = in_data.pos_x;
          y_nxt     = in_data.pos_y;
          glyph_nxt = glyph_bits(in_data.char_code);
          col_nxt   = '0;
          row_nxt   = '0;
          sweep_nxt = '0;
          shift_nxt = CNT_W'(shift_full);
          rd_ok_nxt = (int'(in_data.byte_addr) < FB_BYTES);
          priority if (in_data.req_type == REQ_DRAW) begin
            state_nxt = ST_DRAW_RD;
          end else if (in_data.req_type == REQ_SCROLL) begin
            state_nxt = (shift_full == '0) ? ST_DONE : ST_SCROLL;
          end else if (in_data.req_type == REQ_READ) begin
            state_nxt = ST_READ;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DRAW_RD: begin
        mem_raddr = pix_lin[AW+2:3];
        state_nxt = ST_DRAW_WR;
      end
      ST_DRAW_WR: begin
        mem_we    = pix_ok;
        mem_waddr = pix_lin[AW+2:3];
        mem_wdata = colbits[row_r] ? (mem_rdata | pix_mask) : (mem_rdata & ~pix_mask);
        state_nxt = ST_DRAW_RD;
        if (row_r == 3'(GLYPH_H - 1)) begin
          row_nxt = '0;
          col_nxt = col_r + 1'b1;
          if (col_r == COL_W'(GLYPH_W - 1)) begin
            state_nxt = ST_DONE;
          end
        end else begin
          row_nxt = row_r + 1'b1;
        end
      end
      ST_SCROLL: begin
        // Read the source in the cycle before its destination is written.
        mem_raddr = src[AW-1:0];
        if (sweep_r == CNT_W'(FB_BYTES)) begin
          state_nxt = ST_DONE;
        end else begin
          pend_nxt  = 1'b1;
          pdst_nxt  = sweep_r[AW-1:0];
          pzero_nxt = (src >= (CNT_W + 1)'(FB_BYTES));
          sweep_nxt = sweep_r + 1'b1;
        end
      end
      ST_READ: begin
        res_nxt   = rd_ok_r ? mem_rdata : 8'h00;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        fin_valid = 1'b1;
        if (fin_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign fin_data.read_byte = res_r;
  assign fin_data.done_kind = kind_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      sweep_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sweep_r <= sweep_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    glyph_r <= glyph_nxt;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    col_r   <= col_nxt;
    row_r   <= row_nxt;
    shift_r <= shift_nxt;
    pdst_r  <= pdst_nxt;
    pzero_r <= pzero_nxt;
    kind_r  <= kind_nxt;
    res_r   <= res_nxt;
    rd_ok_r <= rd_ok_nxt;
  end

  `TCF_ASSERT(a_we_state, !mem_we || state_r == ST_CLEAR || state_r == ST_DRAW_WR || state_r == ST_SCROLL, "memory written outside a writing state")
  `TCF_ASSERT_NEXT(a_read_done, state_r == ST_READ, state_r == ST_DONE, "read did not complete")
  `TCF_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, state_r != ST_IDLE, "accepted beat left block idle")

endmodule

[design/text_console_framebuffer.sv]
// ----------------------------------------------------------------------------
// Text console framebuffer
// Monochrome framebuffer with a 5x8 character generator, scroll and readback.
// ----------------------------------------------------------------------------
// Usage: a request beat on the in_ channel is taken when in_valid is high and
// in_stall is low. Each request gives exactly one result beat on the out_
// channel, in order, taken when out_valid is high and out_stall is low.
// A draw request runs one read-modify-write per cell pixel through the single
// frame memory, a read state and then a write state for each pixel. A scroll
// streams the whole memory once, one byte per cycle; a zero-row scroll
// finishes at once. A byte read takes the memory byte in a read state and
// then offers it. The memory port is what sets this pace; one request is in
// progress at a time.
// After reset the block walks every byte of the memory writing zeros, one
// byte per cycle, holding in_stall high.
// Results wait in an output register, so a new request is taken while an
// earlier result is still stalled; the next one only waits to be delivered.
// ----------------------------------------------------------------------------
module text_console_framebuffer #(
  parameter int SCREEN_W = tcf_pkg::SCREEN_W_DEF,
  parameter int SCREEN_H = tcf_pkg::SCREEN_H_DEF,
  parameter int GLYPH_W  = tcf_pkg::GLYPH_W_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  tcf_pkg::tcf_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output tcf_pkg::tcf_out_t out_data
);

  import tcf_pkg::*;

  localparam int FB_BYTES = SCREEN_W * SCREEN_H / 8;
  localparam int AW       = $clog2(FB_BYTES);

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;
  logic          fin_valid;
  logic          fin_ready;
  tcf_out_t      fin_data;

  logic          out_valid_r, out_valid_nxt;
  tcf_out_t      out_data_r, out_data_nxt;

  // The sequencer owns all memory traffic.
  tcf_ctrl #(
    .SCREEN_W (SCREEN_W),
    .SCREEN_H (SCREEN_H),
    .GLYPH_W  (GLYPH_W),
    .AW       (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .fin_valid (fin_valid),
    .fin_ready (fin_ready),
    .fin_data  (fin_data)
  );

  tcf_ram #(
    .WIDTH (8),
    .DEPTH (FB_BYTES)
  ) u_frame_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // The output register takes a new result once the old one is gone or leaves now.
  always_comb begin
    fin_ready     = !out_valid_r || !out_stall;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (fin_valid && fin_ready) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = fin_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
